/* src/srec_pkg.sv */
// ----------------------------------------------------------------------------
// srec_pkg: shared types and constants of the S-record loader
// Holds the token word passed from the character front end to the record
// engine, the result word, event codes and the character constants.
// ----------------------------------------------------------------------------
package srec_pkg;

	// Event codes carried on event_res.
	localparam logic [2:0] EV_WRITE       = 3'd0;
	localparam logic [2:0] EV_ACCEPT      = 3'd1;
	localparam logic [2:0] EV_MISMATCH    = 3'd2;
	localparam logic [2:0] EV_UNSUPPORTED = 3'd3;
	localparam logic [2:0] EV_FINISHED    = 3'd4;

	// Characters of interest in the stream.
	localparam logic [7:0] CHAR_S    = 8'h53;
	localparam logic [7:0] CHAR_0    = 8'h30;
	localparam logic [7:0] CHAR_1    = 8'h31;
	localparam logic [7:0] CHAR_9    = 8'h39;
	localparam logic [7:0] CHAR_UA   = 8'h41;
	localparam logic [7:0] CHAR_UF   = 8'h46;
	localparam logic [7:0] CHAR_LA   = 8'h61;
	localparam logic [7:0] CHAR_LF   = 8'h66;
	localparam logic [7:0] HEX_ALPHA = 8'd10;

	// Reset value of the base address register.
	localparam logic [31:0] BASE_RESET = 32'h0008_0004;

	// One classified character.
	typedef struct packed {
		logic       is_s;
		logic       is_0;
		logic       is_1;
		logic       is_9;
		logic [3:0] nib;
	} token_t;

	// One result word.
	typedef struct packed {
		logic [2:0]  event_res;
		logic [31:0] write_address;
		logic [7:0]  write_data;
	} result_t;

endpackage

/* src/srec_fifo.sv */
// ----------------------------------------------------------------------------
// srec_fifo: small synchronous queue
// Register-based queue with full and empty flags; push and pop may happen in
// the same cycle. The head word is shown while empty is low.
// ----------------------------------------------------------------------------
module srec_fifo #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem[rd_ptr_q];

	// Storage is written at the tail pointer.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= din;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* src/srec_front.sv */
// ----------------------------------------------------------------------------
// srec_front: character classifier
// Turns one received character into a token: flags for the record marker
// and type digits of interest, plus its hex digit value (zero if not hex).
// ----------------------------------------------------------------------------
module srec_front (
	input  logic           [7:0] rx_char,
	output srec_pkg::token_t     tok
);
	import srec_pkg::*;

	logic [7:0] nib_wide;

	// Hex digit decode; anything that is not a hex digit counts as zero.
	always_comb begin
		nib_wide = '0;
		if (rx_char >= CHAR_0 && rx_char <= CHAR_9) begin
			nib_wide = rx_char - CHAR_0;
		end else if (rx_char >= CHAR_UA && rx_char <= CHAR_UF) begin
			nib_wide = rx_char - CHAR_UA + HEX_ALPHA;
		end else if (rx_char >= CHAR_LA && rx_char <= CHAR_LF) begin
			nib_wide = rx_char - CHAR_LA + HEX_ALPHA;
		end
	end

	// Token assembly.
	assign tok.is_s = (rx_char == CHAR_S);
	assign tok.is_0 = (rx_char == CHAR_0);
	assign tok.is_1 = (rx_char == CHAR_1);
	assign tok.is_9 = (rx_char == CHAR_9);
	assign tok.nib  = nib_wide[3:0];

endmodule

/* src/srec_back.sv */
// ----------------------------------------------------------------------------
// srec_back: record engine
// Consumes one token per cycle while results have room, walks S-record fields,
// keeps checksum and write pointer, pushes memory writes and status events.
// ----------------------------------------------------------------------------
module srec_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic       [31:0] base_address,
	input  srec_pkg::token_t  tok,
	input  logic              tok_valid,
	output logic              tok_pop,
	input  logic              res_full,
	output logic              res_push,
	output srec_pkg::result_t res
);
	import srec_pkg::*;

	localparam logic [3:0] PH_HUNT  = 4'd0;
	localparam logic [3:0] PH_TYPE  = 4'd1;
	localparam logic [3:0] PH_CNT_H = 4'd2;
	localparam logic [3:0] PH_CNT_L = 4'd3;
	localparam logic [3:0] PH_AH_H  = 4'd4;
	localparam logic [3:0] PH_AH_L  = 4'd5;
	localparam logic [3:0] PH_AL_H  = 4'd6;
	localparam logic [3:0] PH_AL_L  = 4'd7;
	localparam logic [3:0] PH_DAT_H = 4'd8;
	localparam logic [3:0] PH_DAT_L = 4'd9;
	localparam logic [3:0] PH_CK_H  = 4'd10;
	localparam logic [3:0] PH_CK_L  = 4'd11;
	localparam logic [3:0] PH_DONE  = 4'd12;

	logic [3:0]  phase_q;
	logic [3:0]  high_nibble_q;
	logic [7:0]  addr_hi_q;
	logic [7:0]  bytes_left_q;
	logic [7:0]  sum_q;
	logic [31:0] write_pointer_q;

	logic [3:0]  phase_d;
	logic [3:0]  high_nibble_d;
	logic [7:0]  addr_hi_d;
	logic [7:0]  bytes_left_d;
	logic [7:0]  sum_d;
	logic [31:0] write_pointer_d;
	logic        res_valid;
	logic [7:0]  byte_v;
	logic [7:0]  left_dec;

	// A token is taken whenever one waits and the result queue has room.
	assign tok_pop  = tok_valid && !res_full;
	assign res_push = tok_pop && res_valid;
	assign byte_v   = {high_nibble_q, tok.nib};
	assign left_dec = bytes_left_q - 8'd1;

	// Field walker.
	always_comb begin
		phase_d         = phase_q;
		high_nibble_d   = high_nibble_q;
		addr_hi_d       = addr_hi_q;
		bytes_left_d    = bytes_left_q;
		sum_d           = sum_q;
		write_pointer_d = write_pointer_q;
		res_valid       = 1'b0;
		res             = '0;
		case (phase_q)
			PH_HUNT: begin
				if (tok.is_s) begin
					phase_d = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (tok.is_0) begin
					phase_d = PH_HUNT;
				end else if (tok.is_1) begin
					sum_d   = '0;
					phase_d = PH_CNT_H;
				end else if (tok.is_9) begin
					phase_d       = PH_DONE;
					res_valid     = 1'b1;
					res.event_res = EV_FINISHED;
				end else begin
					phase_d       = PH_HUNT;
					res_valid     = 1'b1;
					res.event_res = EV_UNSUPPORTED;
				end
			end
			PH_CNT_H, PH_AH_H, PH_AL_H, PH_DAT_H, PH_CK_H: begin
				high_nibble_d = tok.nib;
				phase_d       = phase_q + 4'd1;
			end
			PH_CNT_L: begin
				bytes_left_d = (byte_v >= 8'd3) ? byte_v - 8'd3 : 8'd0;
				sum_d        = sum_q + byte_v;
				phase_d      = PH_AH_H;
			end
			PH_AH_L: begin
				addr_hi_d = byte_v;
				sum_d     = sum_q + byte_v;
				phase_d   = PH_AL_H;
			end
			PH_AL_L: begin
				sum_d           = sum_q + byte_v;
				write_pointer_d = base_address + {16'd0, addr_hi_q, byte_v};
				phase_d         = (bytes_left_q != 8'd0) ? PH_DAT_H : PH_CK_H;
			end
			PH_DAT_L: begin
				sum_d             = sum_q + byte_v;
				write_pointer_d   = write_pointer_q + 32'd1;
				bytes_left_d      = left_dec;
				phase_d           = (left_dec != 8'd0) ? PH_DAT_H : PH_CK_H;
				res_valid         = 1'b1;
				res.event_res     = EV_WRITE;
				res.write_address = write_pointer_q;
				res.write_data    = byte_v;
			end
			PH_CK_L: begin
				phase_d       = PH_HUNT;
				res_valid     = 1'b1;
				res.event_res = (byte_v == ~sum_q) ? EV_ACCEPT : EV_MISMATCH;
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// State registers advance on each consumed token.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HUNT;
			high_nibble_q   <= '0;
			addr_hi_q       <= '0;
			bytes_left_q    <= '0;
			sum_q           <= '0;
			write_pointer_q <= '0;
		end else if (tok_pop) begin
			phase_q         <= phase_d;
			high_nibble_q   <= high_nibble_d;
			addr_hi_q       <= addr_hi_d;
			bytes_left_q    <= bytes_left_d;
			sum_q           <= sum_d;
			write_pointer_q <= write_pointer_d;
		end
	end

	// Once the load has finished the engine never leaves that phase.
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |=> (phase_q == PH_DONE))
		else $error("srec_back: left finished phase");

	// Memory writes come only from the low digit of a data byte.
	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.event_res == EV_WRITE) |-> (phase_q == PH_DAT_L))
		else $error("srec_back: memory write outside data field");

	// Each data byte advances the write pointer by one.
	a_ptr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_pop && phase_q == PH_DAT_L)
		|=> (write_pointer_q == $past(write_pointer_q) + 32'd1))
		else $error("srec_back: write pointer did not advance");

	// No result is produced without consuming a token.
	a_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (tok_valid && !res_full))
		else $error("srec_back: result pushed without a token");

endmodule

/* src/srec_s19_loader.sv */
// Path: a pushed character is held in the token queue, and its result (if any)
// is written into the result queue before it shows on the result ports.
// Throughput: one character per cycle, set by the record engine, which
// consumes one token per cycle while the result queue has room.
// Reset: arst_n clears the queues and returns the parser to hunting for S;
// base_address resets to 0x80004.
// ----------------------------------------------------------------------------
// srec_s19_loader: S19 record loader
// Classifies received characters into a token queue; the record engine
// drains it and queues memory writes and status events for the consumer.
// ----------------------------------------------------------------------------
module srec_s19_loader #(
	parameter int TOKEN_DEPTH  = 4,
	parameter int RESULT_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        push,
	input  logic [7:0]  rx_char,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output logic [2:0]  event_res,
	output logic [31:0] write_address,
	output logic [7:0]  write_data
);
	import srec_pkg::*;

	localparam int TW = $bits(token_t);
	localparam int RW = $bits(result_t);

	logic [31:0]   base_address_q;
	token_t        tok_in;
	token_t        tok_out;
	logic [TW-1:0] tok_vec;
	logic          tok_empty;
	logic          tok_pop;
	result_t       res_in;
	result_t       res_out;
	logic [RW-1:0] res_vec;
	logic          res_full;
	logic          res_push;

	// Base address register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address_q <= BASE_RESET;
		end else if (cfg_we) begin
			base_address_q <= cfg_wdata;
		end
	end

	// Front end: classify each accepted character.
	srec_front u_front (
		.rx_char (rx_char),
		.tok     (tok_in)
	);

	// Token queue between front end and record engine.
	srec_fifo #(
		.DEPTH (TOKEN_DEPTH),
		.WIDTH (TW)
	) u_tok_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (tok_in),
		.full   (full),
		.pop    (tok_pop),
		.dout   (tok_vec),
		.empty  (tok_empty)
	);

	assign tok_out = tok_vec;

	// Record engine.
	srec_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.base_address (base_address_q),
		.tok          (tok_out),
		.tok_valid    (!tok_empty),
		.tok_pop      (tok_pop),
		.res_full     (res_full),
		.res_push     (res_push),
		.res          (res_in)
	);

	// Result queue toward the consumer.
	srec_fifo #(
		.DEPTH (RESULT_DEPTH),
		.WIDTH (RW)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_vec),
		.empty  (empty)
	);

	assign res_out       = res_vec;
	assign event_res     = res_out.event_res;
	assign write_address = res_out.write_address;
	assign write_data    = res_out.write_data;

endmodule
